// ----- sv/gcsd_pkg.sv -----
// Shared constants and types for the geometry-free cycle-slip detector.
package gcsd_pkg;

  // Table geometry: one entry per satellite and signal pair
  localparam int NUM_SATS    = 64;
  localparam int NUM_SIGNALS = 4;
  localparam int TBL_DEPTH   = NUM_SATS * NUM_SIGNALS;
  localparam int TBL_AW      = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  // Field widths
  localparam int TIME_W  = 40;
  localparam int VALUE_W = 32;

  // Shared multiplier: operand A holds |dgf| or the scaled bound, B a small factor
  localparam int MUL_A_W = VALUE_W + 1;
  localparam int MUL_B_W = 15;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef logic [TBL_AW-1:0]  tbl_idx_t;
  typedef logic [TIME_W-1:0]  time_ms_t;
  typedef logic [MUL_A_W-1:0] mul_a_t;
  typedef logic [MUL_B_W-1:0] mul_b_t;
  typedef logic [MUL_P_W-1:0] mul_p_t;

  // Table write request
  typedef struct packed {
    logic               en;
    tbl_idx_t           idx;
    logic [VALUE_W-1:0] gf_value;
    time_ms_t           epoch_ms;
  } tbl_wr_t;

  // Table read request
  typedef struct packed {
    logic     en;
    tbl_idx_t idx;
  } tbl_rd_t;

endpackage

// ----- sv/gf_cycle_slip_detector.sv -----
// Top level: sequencer, bound logic and slip compare around the shared multiplier.
//
// Each request runs from start to the result strobe through a table read, two
// passes through the one shared multiplier (|dgf|*30000, then the scaled bound
// times the elevation factor) and a compare. busy is high in S_CALC, S_MUL2 and
// S_CMP; a new request may be issued in the same cycle as the strobe. out_strobe
// is high for exactly one cycle and out_slip_flag is valid only then; the
// receiver cannot stall the block. History entries start out empty after
// reset, with no clearing pass needed. cfg_wdata is written to the start epoch
// when cfg_we is high; only while idle, which the user must ensure, not the block.
module gf_cycle_slip_detector (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [5:0]                   in_sat_index,
  input  logic [1:0]                   in_signal_index,
  input  gcsd_pkg::time_ms_t           in_epoch_ms,
  input  logic signed [14:0]           in_elevation_cdeg,
  input  logic signed [31:0]           in_gf_value,
  input  logic                         in_earlier_flag,
  output logic                         out_strobe,
  output logic                         out_slip_flag,
  input  logic                         cfg_we,
  input  gcsd_pkg::time_ms_t           cfg_wdata
);
  import gcsd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_MUL2, S_CMP} state_t;

  localparam logic [16:0] BX20_SHORT  = 17'd10000;
  localparam logic [16:0] BX20_OFFSET = 17'd10000;
  localparam logic [16:0] BX20_MID    = 17'd30000;
  localparam logic [16:0] BX20_LONG   = 17'd50000;
  localparam logic [16:0] BX20_MAX    = 17'd70000;
  localparam mul_b_t      DIFF_SCALE  = 15'd30000;
  localparam mul_b_t      FLAT_FACTOR = 15'd1500;

  state_t   state_r, state_nxt;
  time_ms_t start_time_r;

  // Request holding registers
  tbl_idx_t           idx_r;
  logic               in_range_r;
  logic               skip_r;
  time_ms_t           epoch_r;
  logic signed [14:0] elev_r;
  logic signed [31:0] gf_r;
  logic               earlier_r;
  logic [16:0]        bx20_r, bx20_nxt;
  mul_b_t             factor_r, factor_nxt;
  mul_p_t             lhs_r;
  logic               out_strobe_r, out_slip_r;

  logic               accept;
  logic               in_range;
  tbl_idx_t           in_idx;
  tbl_rd_t            rd_req;
  tbl_wr_t            wr_req;
  logic [VALUE_W-1:0] rd_value;
  time_ms_t           rd_time;
  logic               rd_written;
  logic signed [VALUE_W:0] diff;
  mul_a_t             abs_diff;
  logic signed [TIME_W:0]  dt;
  logic signed [15:0]      elev_ext;
  logic signed [15:0]      slope_factor;
  mul_a_t             mul_a;
  mul_b_t             mul_b;
  mul_p_t             product;

  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);
  assign in_range = (int'(in_sat_index) < NUM_SATS) && (int'(in_signal_index) < NUM_SIGNALS);
  assign in_idx   = TBL_AW'(int'(in_sat_index) * NUM_SIGNALS + int'(in_signal_index));

  // Read the pair's history as the request is taken
  assign rd_req.en  = accept;
  assign rd_req.idx = in_idx;

  // Store the new value and epoch once the old ones are read
  assign wr_req.en       = (state_r == S_CALC) && in_range_r;
  assign wr_req.idx      = idx_r;
  assign wr_req.gf_value = gf_r;
  assign wr_req.epoch_ms = epoch_r;

  gcsd_table u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_req      (rd_req),
    .wr_req      (wr_req),
    .rd_gf_value (rd_value),
    .rd_epoch_ms (rd_time),
    .rd_written  (rd_written)
  );

  // Absolute change of the value; an empty entry acts as zero
  always_comb begin
    diff = $signed({gf_r[31], gf_r}) -
           (rd_written ? $signed({rd_value[VALUE_W-1], rd_value}) : '0);
    abs_diff = diff[VALUE_W] ? mul_a_t'(-diff) : mul_a_t'(diff);
  end

  // Base bound times 20 from the time gap; empty entries get the widest bound
  always_comb begin
    dt = $signed({1'b0, epoch_r}) - $signed({1'b0, rd_time});
    if (!rd_written) begin
      bx20_nxt = BX20_MAX;
    end else if (dt > 0 && dt <= 41'sd1000) begin
      bx20_nxt = BX20_SHORT;
    end else if (dt > 41'sd1000 && dt <= 41'sd20000) begin
      bx20_nxt = dt[16:0] + BX20_OFFSET;
    end else if (dt > 41'sd20000 && dt <= 41'sd60000) begin
      bx20_nxt = BX20_MID;
    end else if (dt > 41'sd60000 && dt <= 41'sd100000) begin
      bx20_nxt = BX20_LONG;
    end else begin
      bx20_nxt = BX20_MAX;
    end
  end

  // Elevation factor: widen the bound below 15 degrees
  always_comb begin
    elev_ext     = 16'(elev_r);
    slope_factor = 16'sd3000 - elev_ext;
    factor_nxt   = (elev_r <= 15'sd1500) ? slope_factor[14:0] : FLAT_FACTOR;
  end

  // Feed the shared multiplier: first the change, then the bound
  always_comb begin
    case (state_r)
      S_CALC: begin
        mul_a = abs_diff;
        mul_b = DIFF_SCALE;
      end
      S_MUL2: begin
        mul_a = mul_a_t'(bx20_r);
        mul_b = factor_r;
      end
      default: begin
        mul_a = abs_diff;
        mul_b = DIFF_SCALE;
      end
    endcase
  end

  gcsd_mult u_mult (
    .clk     (clk),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .product (product)
  );

  // Advance the sequencer
  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = start ? S_CALC : S_IDLE;
      S_CALC:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_CMP;
      S_CMP:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, configuration and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      start_time_r <= '0;
      out_strobe_r <= 1'b0;
      out_slip_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == S_CMP);
      if (cfg_we) begin
        start_time_r <= cfg_wdata;
      end
      if (state_r == S_CMP) begin
        out_slip_r <= earlier_r || (in_range_r && !skip_r && (lhs_r > product));
      end
    end
  end

  // Capture the request and intermediate results
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r      <= in_idx;
      in_range_r <= in_range;
      skip_r     <= (in_epoch_ms == start_time_r);
      epoch_r    <= in_epoch_ms;
      elev_r     <= in_elevation_cdeg;
      gf_r       <= in_gf_value;
      earlier_r  <= in_earlier_flag;
    end
    if (state_r == S_CALC) begin
      bx20_r   <= bx20_nxt;
      factor_r <= factor_nxt;
    end
    if (state_r == S_MUL2) begin
      lhs_r <= product;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_slip_flag = out_slip_r;

endmodule

// ----- sv/gcsd_table.sv -----
// Per-pair history table: last value and last epoch, with written flags.
module gcsd_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gcsd_pkg::tbl_rd_t           rd_req,
  input  gcsd_pkg::tbl_wr_t           wr_req,
  output logic [gcsd_pkg::VALUE_W-1:0] rd_gf_value,
  output gcsd_pkg::time_ms_t          rd_epoch_ms,
  output logic                        rd_written
);
  import gcsd_pkg::*;

  logic [VALUE_W-1:0] value_mem [TBL_DEPTH];
  time_ms_t           time_mem  [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] written_r;

  logic [VALUE_W-1:0] rd_value_r;
  time_ms_t           rd_time_r;
  logic               rd_written_r;

  // Write and read the stores; read data is registered
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      value_mem[wr_req.idx] <= wr_req.gf_value;
      time_mem[wr_req.idx]  <= wr_req.epoch_ms;
    end
    if (rd_req.en) begin
      rd_value_r <= value_mem[rd_req.idx];
      rd_time_r  <= time_mem[rd_req.idx];
    end
  end

  // Track which entries hold data; unwritten entries read as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (wr_req.en) begin
        written_r[wr_req.idx] <= 1'b1;
      end
      if (rd_req.en) begin
        rd_written_r <= written_r[rd_req.idx];
      end
    end
  end

  assign rd_gf_value = rd_value_r;
  assign rd_epoch_ms = rd_time_r;
  assign rd_written  = rd_written_r;

endmodule

// ----- sv/gcsd_mult.sv -----
// Shared unsigned multiplier with a registered product.
module gcsd_mult (
  input  logic             clk,
  input  gcsd_pkg::mul_a_t op_a,
  input  gcsd_pkg::mul_b_t op_b,
  output gcsd_pkg::mul_p_t product
);
  import gcsd_pkg::*;

  mul_p_t product_r;

  // Register one product per cycle
  always_ff @(posedge clk) begin
    product_r <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
  end

  assign product = product_r;

endmodule
